/* sv/text_console_scrollback_top_defines.svh */
// ----------------------------------------------------------------------------
// text_console_scrollback_top_defines
// assertion macros shared by the console controller and datapath
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_SCROLLBACK_TOP_DEFINES_SVH
`define TEXT_CONSOLE_SCROLLBACK_TOP_DEFINES_SVH

// condition holds on every clock edge outside reset
`define TCS_ASSERT_HOLDS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define TCS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define TCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/tcs_pkg.sv */
// ----------------------------------------------------------------------------
// tcs_pkg
// shared constants, codes and control types of the text console engine
// ----------------------------------------------------------------------------
package tcs_pkg;

  localparam int HISTORY_ROWS = 128;
  localparam int MAX_COLUMNS  = 128;
  localparam int CHAR_W       = 7;

  localparam logic [7:0] RESET_COLUMNS = 8'd80;
  localparam logic [7:0] RESET_ROWS    = 8'd25;

  // op codes
  localparam logic [1:0] OP_CHAR   = 2'd0;
  localparam logic [1:0] OP_SCROLL = 2'd1;
  localparam logic [1:0] OP_FETCH  = 2'd2;

  // configuration register indexes
  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_ROWS    = 1'b1;

  // character codes
  localparam logic [7:0] CH_NEWLINE   = 8'h0A;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TILDE     = 8'h7E;

  typedef struct packed {
    logic load_in;
    logic prep;
    logic exec;
    logic wipe;
    logic row_next;
    logic ring_adv;
    logic fetch_rd;
    logic fetch_cap;
    logic push;
  } tcs_cmd_t;

  typedef struct packed {
    logic overflow;
    logic is_fetch;
    logic wipe_last;
    logic row_last;
    logic out_free;
  } tcs_status_t;

endpackage

/* sv/tcs_ram.sv */
// ----------------------------------------------------------------------------
// tcs_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module tcs_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/tcs_ctrl.sv */
// ----------------------------------------------------------------------------
// tcs_ctrl
// sequencer of the console engine: clear pass, op steps, row wipe, result push
// ----------------------------------------------------------------------------
`include "text_console_scrollback_top_defines.svh"

module tcs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tcs_pkg::tcs_status_t status,
  output tcs_pkg::tcs_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PREP,
    S_EXEC,
    S_WIPE,
    S_FADDR,
    S_FREAD,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   ready;

  assign in_ready = ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.wipe = 1'b1;
        if (status.wipe_last) begin
          cmd.row_next = 1'b1;
          if (status.row_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (in_valid && ready) begin
          cmd.load_in = 1'b1;
          state_next  = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (status.overflow) begin
          state_next = S_WIPE;
        end else if (status.is_fetch) begin
          state_next = S_FADDR;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_WIPE: begin
        cmd.wipe = 1'b1;
        if (status.wipe_last) begin
          cmd.ring_adv = 1'b1;
          state_next   = S_FINISH;
        end
      end
      S_FADDR: begin
        cmd.fetch_rd = 1'b1;
        state_next   = S_FREAD;
      end
      S_FREAD: begin
        cmd.fetch_cap = 1'b1;
        state_next    = S_FINISH;
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      ready <= 1'b0;
    end else begin
      state <= state_next;
      ready <= (state_next == S_IDLE);
    end
  end

  `TCS_ASSERT_NEXT(a_one_item_at_a_time, in_valid && in_ready, !in_ready,
                   "input taken again while an item is in flight")
  `TCS_ASSERT_IMP(a_push_into_free_slot, cmd.push, status.out_free,
                  "result pushed while output slot is full")
  `TCS_ASSERT_IMP(a_exec_after_prep, state == S_EXEC, $past(state) == S_PREP,
                  "op step entered without address preparation")

endmodule

/* sv/tcs_datapath.sv */
// ----------------------------------------------------------------------------
// tcs_datapath
// cursor, view and ring state, history ram, op arithmetic and result register
// ----------------------------------------------------------------------------
`include "text_console_scrollback_top_defines.svh"

module tcs_datapath #(
  parameter int HISTORY_ROWS = tcs_pkg::HISTORY_ROWS,
  parameter int MAX_COLUMNS  = tcs_pkg::MAX_COLUMNS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tcs_pkg::tcs_cmd_t    cmd,
  output tcs_pkg::tcs_status_t status,
  input  logic                 cfg_valid,
  input  logic                 cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic [1:0]           op,
  input  logic [7:0]           char_code,
  input  logic signed [8:0]    scroll_lines,
  input  logic [6:0]           fetch_row,
  input  logic [6:0]           fetch_col,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 draw_valid,
  output logic [6:0]           draw_col,
  output logic [6:0]           draw_row,
  output logic [6:0]           draw_char,
  output logic                 refresh_needed,
  output logic [6:0]           top_row,
  output logic [6:0]           cell_char,
  output logic [6:0]           cursor_col,
  output logic [6:0]           cursor_row,
  output logic [6:0]           view_back
);

  localparam int CHW   = tcs_pkg::CHAR_W;
  localparam int RW    = $clog2(HISTORY_ROWS + 1);
  localparam int PW    = $clog2(HISTORY_ROWS);
  localparam int CW    = $clog2(MAX_COLUMNS);
  localparam int DEPTH = HISTORY_ROWS * MAX_COLUMNS;
  localparam int AW    = $clog2(DEPTH);
  localparam int BW    = ((RW > 7) ? RW : 7) + 1;
  localparam int SW    = ((RW > 9) ? RW : 9) + 2;
  localparam int TW    = RW + 10;

  // latched input item
  logic [1:0]        op_q;
  logic [7:0]        ch_q;
  logic signed [8:0] scroll_q;
  logic [6:0]        frow_q;
  logic [6:0]        fcol_q;

  // console state
  logic [7:0]    cols_cfg;
  logic [7:0]    rows_cfg;
  logic [PW-1:0] ring_base;
  logic [CW-1:0] cur_col;
  logic [RW-1:0] cur_line;
  logic [RW-1:0] view;

  // sequencing registers
  logic [PW-1:0] row_q;
  logic [CW-1:0] wipe_col;
  logic [RW-1:0] top_q;
  logic          fetch_ok;

  // per-item result
  logic           res_dv;
  logic [6:0]     res_dc;
  logic [6:0]     res_dr;
  logic [CHW-1:0] res_dch;
  logic           res_refresh;
  logic [CHW-1:0] res_cell;

  // ram ports
  logic           ram_we;
  logic [AW-1:0]  ram_addr;
  logic [CW-1:0]  col_sel;
  logic [CHW-1:0] ram_wdata;
  logic [CHW-1:0] ram_rdata;

  // derived values
  logic [7:0]           eff_cols;
  logic [7:0]           eff_rows;
  logic signed [TW-1:0] top_s;
  logic [RW-1:0]        top;
  logic [7:0]           cur_scr_row;
  logic [RW-1:0]        line_inc;

  // step results
  logic [CW-1:0]  col_n;
  logic [RW-1:0]  line_n;
  logic [RW-1:0]  view_n;
  logic           wr_en;
  logic [CW-1:0]  wr_col;
  logic [CHW-1:0] wr_data;
  logic           dv;
  logic           refresh;
  logic           ovf;
  logic           fok;
  logic [PW-1:0]  fetch_phys;
  logic [PW-1:0]  line_phys;

  function automatic logic [PW-1:0] phys_of(input logic [PW-1:0] base,
                                            input logic [BW-1:0] r);
    logic [BW:0] sum;
    sum = (BW + 1)'(base) + (BW + 1)'(r);
    if (sum >= (BW + 1)'(HISTORY_ROWS)) begin
      sum = sum - (BW + 1)'(HISTORY_ROWS);
    end
    return sum[PW-1:0];
  endfunction

  always_comb begin
    if (cols_cfg == 8'd0) begin
      eff_cols = 8'd1;
    end else if (int'(cols_cfg) > MAX_COLUMNS) begin
      eff_cols = 8'(MAX_COLUMNS);
    end else begin
      eff_cols = cols_cfg;
    end
    eff_rows = (rows_cfg == 8'd0) ? 8'd1 : rows_cfg;
  end

  // first history row on screen, floored at zero
  always_comb begin
    top_s = TW'(cur_line) - TW'(eff_rows) + TW'(1) - TW'(view);
    top   = top_s[TW-1] ? '0 : top_s[RW-1:0];
  end

  assign cur_scr_row = (BW'(cur_line) >= BW'(eff_rows)) ? (eff_rows - 8'd1) : 8'(cur_line);
  assign line_inc    = cur_line + RW'(1);
  assign line_phys   = phys_of(ring_base, BW'(cur_line));

  always_comb begin
    logic [CW:0]          col_inc;
    logic [BW-1:0]        br;
    logic signed [SW-1:0] vw;
    logic signed [SW-1:0] sc;
    logic signed [SW-1:0] lw;
    logic signed [SW-1:0] v_s;
    col_n   = cur_col;
    line_n  = cur_line;
    view_n  = view;
    wr_en   = 1'b0;
    wr_col  = cur_col;
    wr_data = ch_q[CHW-1:0];
    dv      = 1'b0;
    refresh = 1'b0;
    ovf     = 1'b0;
    col_inc = (CW + 1)'(cur_col) + (CW + 1)'(1);
    br      = BW'(top_q) + BW'(frow_q);
    fok     = ((eff_rows > 8'd127) || (frow_q < eff_rows[6:0])) &&
              ({1'b0, fcol_q} < eff_cols) && (br <= BW'(cur_line));
    fetch_phys = phys_of(ring_base, br);
    vw      = SW'(view);
    sc      = SW'(scroll_q);
    lw      = SW'(cur_line);
    v_s     = vw + sc;
    case (op_q)
      tcs_pkg::OP_CHAR: begin
        if (ch_q == tcs_pkg::CH_NEWLINE) begin
          col_n  = '0;
          line_n = line_inc;
          view_n = '0;
          if (BW'(line_inc) >= BW'(eff_rows)) begin
            refresh = 1'b1;
          end
          ovf = (line_inc == RW'(HISTORY_ROWS));
        end else if (ch_q == tcs_pkg::CH_BACKSPACE) begin
          if (cur_col != '0) begin
            col_n   = cur_col - CW'(1);
            wr_en   = 1'b1;
            wr_col  = cur_col - CW'(1);
            wr_data = tcs_pkg::CH_SPACE[CHW-1:0];
            dv      = (view == '0);
          end
        end else if (ch_q >= tcs_pkg::CH_SPACE && ch_q <= tcs_pkg::CH_TILDE) begin
          wr_en = 1'b1;
          dv    = (view == '0);
          if (col_inc >= (CW + 1)'(eff_cols)) begin
            col_n  = '0;
            line_n = line_inc;
            if (BW'(line_inc) >= BW'(eff_rows)) begin
              refresh = 1'b1;
            end
            ovf = (line_inc == RW'(HISTORY_ROWS));
          end else begin
            col_n = col_inc[CW-1:0];
          end
        end
        if (ovf) begin
          refresh = 1'b1;
          line_n  = RW'(HISTORY_ROWS - 1);
        end
      end
      tcs_pkg::OP_SCROLL: begin
        if (v_s > lw) begin
          view_n = cur_line;
        end else if (v_s < 0) begin
          view_n = '0;
        end else begin
          view_n = v_s[RW-1:0];
        end
        refresh = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign status.overflow  = ovf;
  assign status.is_fetch  = (op_q == tcs_pkg::OP_FETCH);
  assign status.wipe_last = (wipe_col == CW'(MAX_COLUMNS - 1));
  assign status.row_last  = (row_q == PW'(HISTORY_ROWS - 1));
  assign status.out_free  = !out_valid || out_ready;

  always_comb begin
    if (cmd.wipe) begin
      col_sel = wipe_col;
    end else if (cmd.fetch_rd) begin
      col_sel = CW'(fcol_q);
    end else begin
      col_sel = wr_col;
    end
  end

  assign ram_addr  = AW'(row_q) * AW'(MAX_COLUMNS) + AW'(col_sel);
  assign ram_we    = cmd.wipe || (cmd.exec && wr_en);
  assign ram_wdata = cmd.wipe ? '0 : wr_data;

  tcs_ram #(
    .WIDTH (CHW),
    .DEPTH (DEPTH)
  ) u_history (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  // configuration registers, written whenever the write channel is valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cols_cfg <= tcs_pkg::RESET_COLUMNS;
      rows_cfg <= tcs_pkg::RESET_ROWS;
    end else if (cfg_valid) begin
      case (cfg_index)
        tcs_pkg::REG_COLUMNS: cols_cfg <= cfg_data;
        tcs_pkg::REG_ROWS:    rows_cfg <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_q     <= op;
      ch_q     <= char_code;
      scroll_q <= scroll_lines;
      frow_q   <= fetch_row;
      fcol_q   <= fetch_col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_base <= '0;
      cur_col   <= '0;
      cur_line  <= '0;
      view      <= '0;
      row_q     <= '0;
      wipe_col  <= '0;
    end else begin
      if (cmd.prep) begin
        row_q <= line_phys;
      end
      if (cmd.exec) begin
        cur_col  <= col_n;
        cur_line <= line_n;
        view     <= view_n;
        if (ovf) begin
          // new last row sits where the oldest row was
          row_q <= ring_base;
        end else if (op_q == tcs_pkg::OP_FETCH) begin
          row_q <= fetch_phys;
        end
      end
      if (cmd.wipe) begin
        wipe_col <= status.wipe_last ? '0 : wipe_col + CW'(1);
      end
      if (cmd.row_next) begin
        row_q <= row_q + PW'(1);
      end
      if (cmd.ring_adv) begin
        ring_base <= (ring_base == PW'(HISTORY_ROWS - 1)) ? '0 : ring_base + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      top_q <= top;
    end
    if (cmd.load_in) begin
      res_dv      <= 1'b0;
      res_dc      <= '0;
      res_dr      <= '0;
      res_dch     <= '0;
      res_refresh <= 1'b0;
      res_cell    <= '0;
    end
    if (cmd.exec) begin
      res_dv      <= dv;
      res_dc      <= dv ? 7'(wr_col) : 7'd0;
      res_dr      <= dv ? cur_scr_row[6:0] : 7'd0;
      res_dch     <= dv ? wr_data : '0;
      res_refresh <= refresh;
      fetch_ok    <= fok;
    end
    if (cmd.fetch_cap) begin
      res_cell <= (fetch_ok && ram_rdata != '0) ? ram_rdata : tcs_pkg::CH_SPACE[CHW-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      draw_valid     <= res_dv;
      draw_col       <= res_dc;
      draw_row       <= res_dr;
      draw_char      <= res_dch;
      refresh_needed <= res_refresh;
      top_row        <= 7'(top);
      cell_char      <= res_cell;
      cursor_col     <= 7'(cur_col);
      cursor_row     <= 7'(cur_line);
      view_back      <= 7'(view);
    end
  end

  `TCS_ASSERT_HOLDS(a_line_in_history, cur_line < RW'(HISTORY_ROWS),
                    "cursor row beyond the history")
  `TCS_ASSERT_HOLDS(a_view_within_line, view <= cur_line,
                    "view offset beyond the cursor row")
  `TCS_ASSERT_NEXT(a_push_shows_result, cmd.push, out_valid,
                   "pushed result not presented")

endmodule

/* sv/text_console_scrollback_top.sv */
// ----------------------------------------------------------------------------
// text_console_scrollback_top
// character-cell console engine with a ring-buffered scrollback history
// ----------------------------------------------------------------------------
// channel  | handshake            | payload
// ---------+----------------------+----------------------------------------------
// input    | in_valid / in_ready  | op, char_code, scroll_lines, fetch_row, fetch_col
// result   | out_valid/ out_ready | draw_*, refresh_needed, top_row, cell_char,
//          |                      | cursor_col, cursor_row, view_back
// config   | cfg_valid/ cfg_ready | cfg_index, cfg_data
//
// out_valid rises after the input transaction, set by the prepare / step / push
// sequence plus the address and ram read steps of a fetch; a new item is taken
// only once the last one has been pushed into a free output register.
// a history overflow wipes the new last row (MAX_COLUMNS cells) before the push.
// after reset a clearing pass writes HISTORY_ROWS * MAX_COLUMNS cells (16384 at
// the defaults) before in_ready rises; config writes are taken at all times.
// a stalled result waits in the output register; the next item is accepted meanwhile.
module text_console_scrollback_top #(
  parameter int HISTORY_ROWS = tcs_pkg::HISTORY_ROWS,
  parameter int MAX_COLUMNS  = tcs_pkg::MAX_COLUMNS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        op,
  input  logic [7:0]        char_code,
  input  logic signed [8:0] scroll_lines,
  input  logic [6:0]        fetch_row,
  input  logic [6:0]        fetch_col,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              draw_valid,
  output logic [6:0]        draw_col,
  output logic [6:0]        draw_row,
  output logic [6:0]        draw_char,
  output logic              refresh_needed,
  output logic [6:0]        top_row,
  output logic [6:0]        cell_char,
  output logic [6:0]        cursor_col,
  output logic [6:0]        cursor_row,
  output logic [6:0]        view_back,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data
);

  tcs_pkg::tcs_cmd_t    cmd;
  tcs_pkg::tcs_status_t status;

  assign cfg_ready = 1'b1;

  tcs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tcs_datapath #(
    .HISTORY_ROWS (HISTORY_ROWS),
    .MAX_COLUMNS  (MAX_COLUMNS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .op             (op),
    .char_code      (char_code),
    .scroll_lines   (scroll_lines),
    .fetch_row      (fetch_row),
    .fetch_col      (fetch_col),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .draw_valid     (draw_valid),
    .draw_col       (draw_col),
    .draw_row       (draw_row),
    .draw_char      (draw_char),
    .refresh_needed (refresh_needed),
    .top_row        (top_row),
    .cell_char      (cell_char),
    .cursor_col     (cursor_col),
    .cursor_row     (cursor_row),
    .view_back      (view_back)
  );

endmodule
